[rtl/core/top_five_nearest_cell_vote_assert.svh]
// Assertion macros for the nearest-cell vote block.
// Each macro takes a label, clock, active-low reset, a trigger and a check.
`ifndef TOP_FIVE_NEAREST_CELL_VOTE_ASSERT_SVH
`define TOP_FIVE_NEAREST_CELL_VOTE_ASSERT_SVH

// Check in the same cycle as the trigger.
`define TFNV_ASSERT_NOW(label, clk, rst_n, trig, chk) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (chk)) \
        else $error("tfnv assertion failed");

// Check in the cycle after the trigger.
`define TFNV_ASSERT_NEXT(label, clk, rst_n, trig, chk) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (chk)) \
        else $error("tfnv assertion failed");

`endif

[rtl/core/tfnv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfnv_pkg
// Types and constants shared by the nearest-cell vote block.
// ----------------------------------------------------------------------------
package tfnv_pkg;

    localparam int ERROR_W = 24;
    localparam int ROW_W   = 4;
    localparam int COL_W   = 5;
    localparam int COUNT_W = 3;

    localparam int NEIGHBOURS_DEF   = 5;
    localparam int GRID_COLUMNS_DEF = 32;
    localparam int GRID_ROWS_DEF    = 16;

    localparam logic [ERROR_W-1:0] ERROR_WORST = '1;
    localparam int                 COUNT_MAX   = (1 << COUNT_W) - 1;

    typedef struct packed {
        logic [ERROR_W-1:0] error_value;
        logic [ROW_W-1:0]   cell_row;
        logic [COL_W-1:0]   cell_column;
        logic               last_cell;
    } t_cell_word;

    typedef struct packed {
        logic [ROW_W-1:0]   goal_row;
        logic [COL_W-1:0]   goal_column;
        logic [COUNT_W-1:0] vote_count;
        logic               goal_valid;
    } t_goal_word;

    // Position part of one slot, as handed to the vote.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             filled;
    } t_slot_pos;

    // Snapshot queue handshake, front side and back side.
    typedef struct packed {
        logic push;
        logic full;
    } t_q_wr;

    typedef struct packed {
        logic pop;
        logic valid;
    } t_q_rd;

endpackage

[rtl/core/tfnv_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfnv_if
// Valid/ready channels carrying cell words in and goal words out.
// ----------------------------------------------------------------------------
interface tfnv_cell_if;
    import tfnv_pkg::*;
    logic       valid;
    logic       ready;
    t_cell_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tfnv_goal_if;
    import tfnv_pkg::*;
    logic       valid;
    logic       ready;
    t_goal_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/tfnv_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfnv_front
// Keeps the lowest-error cells in sorted slots; snapshots them on last cell.
// ----------------------------------------------------------------------------
module tfnv_front #(
    parameter int NEIGHBOURS   = tfnv_pkg::NEIGHBOURS_DEF,
    parameter int GRID_COLUMNS = tfnv_pkg::GRID_COLUMNS_DEF,
    parameter int GRID_ROWS    = tfnv_pkg::GRID_ROWS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    tfnv_cell_if.sink                            i_cell,
    output tfnv_pkg::t_q_wr                      o_q_wr_push,
    input  logic                                 i_q_full,
    output tfnv_pkg::t_slot_pos [NEIGHBOURS-1:0] o_snap
);
    import tfnv_pkg::*;

    logic [ERROR_W-1:0] r_err [NEIGHBOURS];
    logic [ERROR_W-1:0] n_err [NEIGHBOURS];
    t_slot_pos          r_pos [NEIGHBOURS];
    t_slot_pos          n_pos [NEIGHBOURS];
    logic [NEIGHBOURS-1:0] lt;
    logic               accept;
    logic               in_grid;
    logic               take;
    t_slot_pos          new_pos;

    assign i_cell.ready = !i_q_full;
    assign accept       = i_cell.valid && i_cell.ready;
    assign in_grid      = (32'(i_cell.data.cell_row) < GRID_ROWS)
                       && (32'(i_cell.data.cell_column) < GRID_COLUMNS);
    assign take         = accept && in_grid;

    assign new_pos.row    = i_cell.data.cell_row;
    assign new_pos.col    = i_cell.data.cell_column;
    assign new_pos.filled = 1'b1;

    // Slots stay sorted, so lt is a run of ones from the insertion point to the last slot.
    always_comb begin
        for (int i = 0; i < NEIGHBOURS; i++) begin
            lt[i] = i_cell.data.error_value < r_err[i];
        end
        n_err[0] = r_err[0];
        n_pos[0] = r_pos[0];
        if (take && lt[0]) begin
            n_err[0] = i_cell.data.error_value;
            n_pos[0] = new_pos;
        end
        for (int i = 1; i < NEIGHBOURS; i++) begin
            n_err[i] = r_err[i];
            n_pos[i] = r_pos[i];
            if (take && lt[i]) begin
                if (lt[i-1]) begin
                    n_err[i] = r_err[i-1];
                    n_pos[i] = r_pos[i-1];
                end else begin
                    n_err[i] = i_cell.data.error_value;
                    n_pos[i] = new_pos;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NEIGHBOURS; i++) begin
            o_snap[i] = n_pos[i];
        end
        o_q_wr_push.push = accept && i_cell.data.last_cell;
        o_q_wr_push.full = i_q_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_cell.data.last_cell)) begin
            for (int i = 0; i < NEIGHBOURS; i++) begin
                r_err[i] <= ERROR_WORST;
                r_pos[i] <= '0;
            end
        end else begin
            for (int i = 0; i < NEIGHBOURS; i++) begin
                r_err[i] <= n_err[i];
                r_pos[i] <= n_pos[i];
            end
        end
    end

endmodule

[rtl/core/tfnv_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfnv_queue
// Two-entry queue of slot snapshots between the front and the vote.
// ----------------------------------------------------------------------------
module tfnv_queue #(
    parameter int NEIGHBOURS = tfnv_pkg::NEIGHBOURS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tfnv_pkg::t_q_wr                      i_wr,
    input  tfnv_pkg::t_slot_pos [NEIGHBOURS-1:0] i_snap,
    output logic                                 o_full,
    output tfnv_pkg::t_q_rd                      o_rd,
    input  logic                                 i_pop,
    output tfnv_pkg::t_slot_pos [NEIGHBOURS-1:0] o_snap
);
    import tfnv_pkg::*;

    typedef t_slot_pos [NEIGHBOURS-1:0] t_snap;

    t_snap      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full   = (r_count == 2'd2);
    assign do_push  = i_wr.push && !o_full;
    assign do_pop   = i_pop && (r_count != 2'd0);
    assign o_rd.valid = (r_count != 2'd0);
    assign o_rd.pop   = do_pop;
    assign o_snap   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_snap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

[rtl/core/tfnv_vote.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfnv_vote
// Counts matching slots, then picks the winner into the output register.
// ----------------------------------------------------------------------------
module tfnv_vote #(
    parameter int NEIGHBOURS = tfnv_pkg::NEIGHBOURS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tfnv_pkg::t_q_rd                      i_rd,
    input  tfnv_pkg::t_slot_pos [NEIGHBOURS-1:0] i_snap,
    output logic                                 o_pop,
    tfnv_goal_if.source                          o_goal
);
    import tfnv_pkg::*;

    localparam int CNT_W = $clog2(NEIGHBOURS + 1);

    t_slot_pos        r_s1_pos [NEIGHBOURS];
    logic [CNT_W-1:0] r_s1_cnt [NEIGHBOURS];
    logic [CNT_W-1:0] n_cnt    [NEIGHBOURS];
    logic             r_s1_valid;
    logic             s1_adv;
    logic             s1_take;
    t_goal_word       r_out;
    logic             r_out_valid;
    t_goal_word       n_out;

    assign s1_take = r_s1_valid && (!r_out_valid || o_goal.ready);
    assign s1_adv  = !r_s1_valid || s1_take;
    assign o_pop   = i_rd.valid && s1_adv;

    // Matches per slot; empty slots neither count nor are counted.
    always_comb begin
        logic [NEIGHBOURS-1:0] match;
        for (int i = 0; i < NEIGHBOURS; i++) begin
            for (int j = 0; j < NEIGHBOURS; j++) begin
                match[j] = i_snap[j].filled && i_snap[i].filled
                        && (i_snap[j].row == i_snap[i].row)
                        && (i_snap[j].col == i_snap[i].col);
            end
            n_cnt[i] = CNT_W'($countones(match));
        end
    end

    // Most votes wins; ties go to the smaller row, then the smaller column.
    always_comb begin
        logic             have;
        logic [CNT_W-1:0] best_cnt;
        logic [ROW_W-1:0] best_row;
        logic [COL_W-1:0] best_col;
        int               sat;
        have     = 1'b0;
        best_cnt = '0;
        best_row = '0;
        best_col = '0;
        for (int i = 0; i < NEIGHBOURS; i++) begin
            if (r_s1_pos[i].filled
                && (!have || (r_s1_cnt[i] > best_cnt)
                    || ((r_s1_cnt[i] == best_cnt)
                        && ({r_s1_pos[i].row, r_s1_pos[i].col} < {best_row, best_col})))) begin
                have     = 1'b1;
                best_cnt = r_s1_cnt[i];
                best_row = r_s1_pos[i].row;
                best_col = r_s1_pos[i].col;
            end
        end
        sat = (int'(best_cnt) > COUNT_MAX) ? COUNT_MAX : int'(best_cnt);
        n_out.goal_row    = best_row;
        n_out.goal_column = best_col;
        n_out.vote_count  = COUNT_W'(sat);
        n_out.goal_valid  = have;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int i = 0; i < NEIGHBOURS; i++) begin
                r_s1_pos[i] <= i_snap[i];
                r_s1_cnt[i] <= n_cnt[i];
            end
        end
        if (s1_take) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= o_pop;
            end
            if (s1_take) begin
                r_out_valid <= 1'b1;
            end else if (o_goal.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_goal.valid = r_out_valid;
    assign o_goal.data  = r_out;

endmodule

[rtl/core/top_five_nearest_cell_vote.sv]
`timescale 1ns / 1ps
// A scan's snapshot passes the queue, the count stage and the output register.
// One cell per cycle if the queue has room; slot inserts are parallel compares.
// The vote runs as a two-stage pipeline behind a two-entry snapshot queue,
// so a goal word per cycle can leave while the output is not stalled.
// Reset: synchronous, active low; slots empty, queue and pipeline drained.
// ----------------------------------------------------------------------------
// top_five_nearest_cell_vote
// Nearest-neighbour majority vote over a stream of scanned grid cells.
// ----------------------------------------------------------------------------
module top_five_nearest_cell_vote #(
    parameter int NEIGHBOURS   = tfnv_pkg::NEIGHBOURS_DEF,
    parameter int GRID_COLUMNS = tfnv_pkg::GRID_COLUMNS_DEF,
    parameter int GRID_ROWS    = tfnv_pkg::GRID_ROWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tfnv_cell_if.sink   i_cell,
    tfnv_goal_if.source o_goal
);
    import tfnv_pkg::*;

    t_q_wr                      q_wr;
    t_q_rd                      q_rd;
    logic                       q_full;
    logic                       q_pop;
    t_slot_pos [NEIGHBOURS-1:0] front_snap;
    t_slot_pos [NEIGHBOURS-1:0] back_snap;

    tfnv_front #(
        .NEIGHBOURS   (NEIGHBOURS),
        .GRID_COLUMNS (GRID_COLUMNS),
        .GRID_ROWS    (GRID_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cell      (i_cell),
        .o_q_wr_push (q_wr),
        .i_q_full    (q_full),
        .o_snap      (front_snap)
    );

    tfnv_queue #(
        .NEIGHBOURS (NEIGHBOURS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_snap  (front_snap),
        .o_full  (q_full),
        .o_rd    (q_rd),
        .i_pop   (q_pop),
        .o_snap  (back_snap)
    );

    tfnv_vote #(
        .NEIGHBOURS (NEIGHBOURS)
    ) u_vote (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (q_rd),
        .i_snap  (back_snap),
        .o_pop   (q_pop),
        .o_goal  (o_goal)
    );

endmodule

[rtl/core/tfnv_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfnv_checker
// Port-level checks on the goal channel of the nearest-cell vote block.
// ----------------------------------------------------------------------------
`include "top_five_nearest_cell_vote_assert.svh"

module tfnv_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_goal_valid,
    input logic                 i_goal_ready,
    input tfnv_pkg::t_goal_word i_goal_data
);
    import tfnv_pkg::*;

    logic stalled;
    logic goal_empty;
    logic goal_real;
    logic goal_zero;

    assign stalled    = i_goal_valid && !i_goal_ready;
    assign goal_empty = i_goal_valid && !i_goal_data.goal_valid;
    assign goal_real  = i_goal_valid && i_goal_data.goal_valid;
    assign goal_zero  = (i_goal_data.goal_row == '0) && (i_goal_data.goal_column == '0)
                     && (i_goal_data.vote_count == '0);

    // A stalled goal word holds until taken.
    `TFNV_ASSERT_NEXT(chk_valid_hold, i_clk, i_rst_n, stalled, i_goal_valid)
    `TFNV_ASSERT_NEXT(chk_data_hold, i_clk, i_rst_n, stalled, $stable(i_goal_data))
    // An empty vote reports all zero; a real winner has at least one vote.
    `TFNV_ASSERT_NOW(chk_empty_zero, i_clk, i_rst_n, goal_empty, goal_zero)
    `TFNV_ASSERT_NOW(chk_winner_votes, i_clk, i_rst_n, goal_real, i_goal_data.vote_count != '0)
    // Nothing leaves in the first cycle after reset.
    `TFNV_ASSERT_NOW(chk_reset_quiet, i_clk, i_rst_n, $past(!i_rst_n), !i_goal_valid)

endmodule

bind top_five_nearest_cell_vote tfnv_checker u_tfnv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_goal_valid (o_goal.valid),
    .i_goal_ready (o_goal.ready),
    .i_goal_data  (o_goal.data)
);
